// ===== design/vpsc_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the length-prefixed utf-8 string checker
// no dependencies
package vpsc_pkg;

  // most bytes in one length prefix
  localparam int unsigned PREFIX_MAX_BYTES = 5;
  localparam int unsigned PIDX_W = 3;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned MAXC_W = 15;
  localparam logic [MAXC_W-1:0] MAX_CHARS_RST = 15'h7fff;

  // register indexes
  localparam logic REG_MAX_CHARS = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_NEGATIVE  = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic {
    PH_PREFIX  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  typedef struct packed {
    logic             has_data;
    logic [7:0]       data_byte;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] char_count;
    logic [LEN_W-1:0] byte_length;
  } res_t;

endpackage

// ===== design/vpsc_regs.sv =====
`timescale 1ns / 1ps
// apb-style configuration register file: max_chars
// depends on vpsc_pkg
module vpsc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [vpsc_pkg::MAXC_W-1:0]       max_chars
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= vpsc_pkg::MAX_CHARS_RST;
    end else if (wr && paddr[2] == vpsc_pkg::REG_MAX_CHARS) begin
      max_chars <= pwdata[vpsc_pkg::MAXC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == vpsc_pkg::REG_MAX_CHARS) begin
      prdata = {{(32 - vpsc_pkg::MAXC_W){1'b0}}, max_chars};
    end
  end

endmodule

// ===== design/vpsc_step.sv =====
`timescale 1ns / 1ps
// per-byte decoder: prefix accumulation, length checks, payload count
// depends on vpsc_pkg
module vpsc_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [7:0]                        in_byte,
  input  logic                              end_of_data,
  input  logic [vpsc_pkg::MAXC_W-1:0]       max_chars,
  output logic                              res_valid,
  output vpsc_pkg::res_t                    res
);

  localparam int unsigned LW = vpsc_pkg::LEN_W;
  localparam int unsigned PW = vpsc_pkg::PIDX_W;

  vpsc_pkg::phase_t phase, phase_next;
  logic [31:0]      length_accum, length_accum_next;
  logic [PW-1:0]    prefix_idx, prefix_idx_next;
  logic [LW-1:0]    bytes_left, bytes_left_next;
  logic [LW-1:0]    chars_seen, chars_seen_next;

  logic [31:0]      part;
  logic [31:0]      acc_new;
  logic [PW-1:0]    idx_inc;
  logic [4:0]       shamt;
  logic [LW-1:0]    limit;
  logic [LW-1:0]    chars_inc;
  logic [LW-1:0]    left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vpsc_pkg::PH_PREFIX;
      length_accum <= '0;
      prefix_idx   <= '0;
      bytes_left   <= '0;
      chars_seen   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      prefix_idx   <= prefix_idx_next;
      bytes_left   <= bytes_left_next;
      chars_seen   <= chars_seen_next;
    end
  end

  always_comb begin
    shamt     = 5'(prefix_idx) * 5'd7;
    part      = {25'd0, in_byte[6:0]} << shamt;
    acc_new   = length_accum | part;
    idx_inc   = prefix_idx + 1'b1;
    limit     = {max_chars, 2'b00};
    chars_inc = chars_seen + ((in_byte[7:6] != 2'b10) ? LW'(1) : LW'(0));
    left_dec  = bytes_left - 1'b1;

    phase_next        = phase;
    length_accum_next = length_accum;
    prefix_idx_next   = prefix_idx;
    bytes_left_next   = bytes_left;
    chars_seen_next   = chars_seen;
    res_valid         = 1'b0;
    res               = '0;

    case (phase)
      vpsc_pkg::PH_PAYLOAD: begin
        res_valid = 1'b1;
        if (end_of_data) begin
          res.last          = 1'b1;
          res.status        = vpsc_pkg::ST_OVERFLOW;
          res.char_count    = chars_seen;
          res.byte_length   = length_accum[LW-1:0];
          phase_next        = vpsc_pkg::PH_PREFIX;
          length_accum_next = '0;
          prefix_idx_next   = '0;
          bytes_left_next   = '0;
          chars_seen_next   = '0;
        end else begin
          res.has_data    = 1'b1;
          res.data_byte   = in_byte;
          res.char_count  = chars_inc;
          res.byte_length = length_accum[LW-1:0];
          chars_seen_next = chars_inc;
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            res.last = 1'b1;
            if (chars_inc > {2'b00, max_chars}) begin
              res.status = vpsc_pkg::ST_TOO_MANY;
            end
            phase_next        = vpsc_pkg::PH_PREFIX;
            length_accum_next = '0;
            prefix_idx_next   = '0;
            bytes_left_next   = '0;
            chars_seen_next   = '0;
          end
        end
      end
      vpsc_pkg::PH_PREFIX: begin
        if (end_of_data) begin
          // nothing read yet: between strings, no transfer
          if (prefix_idx != '0) begin
            res_valid         = 1'b1;
            res.last          = 1'b1;
            res.status        = vpsc_pkg::ST_OVERFLOW;
            length_accum_next = '0;
            prefix_idx_next   = '0;
          end
        end else if (in_byte[7] && idx_inc < PW'(vpsc_pkg::PREFIX_MAX_BYTES)) begin
          length_accum_next = acc_new;
          prefix_idx_next   = idx_inc;
        end else begin
          length_accum_next = '0;
          prefix_idx_next   = '0;
          if (!acc_new[31] && acc_new[30:0] > {14'd0, limit}) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = vpsc_pkg::ST_TOO_LONG;
          end else if (acc_new[31]) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = vpsc_pkg::ST_NEGATIVE;
          end else if (acc_new == '0) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
          end else begin
            phase_next        = vpsc_pkg::PH_PAYLOAD;
            length_accum_next = {15'd0, acc_new[LW-1:0]};
            bytes_left_next   = acc_new[LW-1:0];
            chars_seen_next   = '0;
          end
        end
      end
      default: begin
        phase_next = vpsc_pkg::PH_PREFIX;
      end
    endcase
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != vpsc_pkg::ST_OK |-> res.last)
    else $error("error result without last");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == vpsc_pkg::PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_last_to_prefix: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.last |=> phase == vpsc_pkg::PH_PREFIX && prefix_idx == '0)
    else $error("final result did not return to prefix");

  a_prefix_clean: assert property (@(posedge clk) disable iff (rst)
    phase == vpsc_pkg::PH_PREFIX |-> chars_seen == '0 && bytes_left == '0)
    else $error("stale payload counters in prefix phase");

endmodule

// ===== design/varint_prefixed_utf8_string_checker_unit.sv =====
`timescale 1ns / 1ps
// top level of the length-prefixed utf-8 string checker
// depends on vpsc_pkg, vpsc_regs, vpsc_step
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   in_byte, end_of_data
//  out      source     out_valid / out_ready has_data, data_byte, last, status,
//                                            char_count, byte_length
//  cfg      apb slave  psel/penable/pready   paddr, pwdata, prdata (max_chars)
//
// one byte per cycle sustained while out_ready is high; a byte's result passes from the
// input register through the decode step into the result register
// the decode state (phase, length, counters) lives in one registered feedback loop
// rst is synchronous: state returns to reading a length prefix, max_chars to 32767
// a stalled result holds in the result register while the input register keeps
// one more byte; in_ready drops only when both are full and out_ready is low
module varint_prefixed_utf8_string_checker_unit (
  input  logic                           clk,
  input  logic                           rst,
  // byte stream in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           end_of_data,
  // results out
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           has_data,
  output logic [7:0]                     data_byte,
  output logic                           last,
  output logic [2:0]                     status,
  output logic [vpsc_pkg::LEN_W-1:0]     char_count,
  output logic [vpsc_pkg::LEN_W-1:0]     byte_length,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // input register
  logic                          in_full;
  logic [7:0]                    in_byte_q;
  logic                          in_eod_q;

  // result register
  vpsc_pkg::res_t                out_q;

  logic                          advance;
  logic                          res_valid;
  vpsc_pkg::res_t                res;
  logic [vpsc_pkg::MAXC_W-1:0]   max_chars;

  // the held byte moves on when the result register is free or being drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_q <= in_byte;
      in_eod_q  <= end_of_data;
    end
  end

  vpsc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_chars (max_chars)
  );

  vpsc_step u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .in_byte     (in_byte_q),
    .end_of_data (in_eod_q),
    .max_chars   (max_chars),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register: a new result loads when the step fires with one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign has_data    = out_q.has_data;
  assign data_byte   = out_q.data_byte;
  assign last        = out_q.last;
  assign status      = out_q.status;
  assign char_count  = out_q.char_count;
  assign byte_length = out_q.byte_length;

  // a stalled result must never be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("result register overwritten while stalled");

  // a full input register with a free output side always drains
  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_full && !out_valid |=> !in_full || $past(in_valid && in_ready))
    else $error("input register failed to drain");

  // a data-carrying transfer always reports a nonzero declared length
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data |-> byte_length != '0)
    else $error("payload byte with zero length");

endmodule
